// File: src/fbw_pkg.sv
package fbw_pkg;

    // Framebuffer size in bytes and the offset width used by the range fields.
    localparam int unsigned FB_BYTES = 1048576;
    localparam int          OFF_W    = 21;

    // The store is split into four byte banks so that any 1, 2 or 4 byte
    // access touches each bank at most once.
    localparam int NB     = 4;
    localparam int ROWS   = FB_BYTES / NB;
    localparam int ROW_W  = $clog2(ROWS);

    localparam int BASE_W    = 32;
    localparam int CFG_IDX_W = 1;
    localparam int IN_W      = 112;
    localparam int OUT_W     = 80;
    localparam int OP_W      = 3;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_BASE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_READY = 1'd1;

    localparam logic [OP_W-1:0] OP_LOAD    = 3'd0;
    localparam logic [OP_W-1:0] OP_STORE   = 3'd1;
    localparam logic [OP_W-1:0] OP_COMMIT  = 3'd2;
    localparam logic [OP_W-1:0] OP_FLUSH   = 3'd3;
    localparam logic [OP_W-1:0] OP_REQUEUE = 3'd4;

    // Listed from the highest bits down, so in_window sits at bit 0.
    typedef struct packed {
        logic [OFF_W-1:0] flush_end;
        logic [OFF_W-1:0] flush_start;
        logic             flush_valid;
        logic [31:0]      read_data;
        logic             in_window;
    } t_result;

    localparam int RES_W = $bits(t_result);

endpackage

// File: src/fbw_ram.sv
module fbw_ram #(
    parameter int P_WIDTH = 8,
    parameter int P_DEPTH = 256
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic                       i_re,
    input  logic [$clog2(P_DEPTH)-1:0] i_addr,
    input  logic [P_WIDTH-1:0]         i_wdata,
    output logic [P_WIDTH-1:0]         o_rdata
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/framebuffer_window_dirty_range.sv
// Framebuffer window with dirty range tracking.
//
// Input stream: tuser carries the opcode (load, store, commit, flush,
// requeue); tdata carries the access and requeue fields. Each input
// transaction yields exactly one result transaction on the output stream.
// Configuration (window base, display ready) is written through a plain
// write port and takes effect for the next transaction.
//
// A result becomes valid on the output once its input transaction has passed
// the read stage (the byte banks have a registered read) and then the output
// register. One transaction is accepted per cycle as long as the output side
// takes results. When the receiver stalls, one result waits in the output
// register and one in the read stage; after that the input ready drops.
//
// After reset the block clears the frame store, one row of four bytes per
// cycle. Input ready stays low during that pass; configuration writes are
// taken at any time.
module framebuffer_window_dirty_range
    import fbw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BASE_W-1:0]    i_cfg_wdata,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // bus_address[31:0], access_bytes[34:32], write_data[66:35],
    // requeue_start[87:67], requeue_end[108:88], zero fill above
    input  logic [IN_W-1:0]      i_s_axis_tdata,
    // opcode[2:0]
    input  logic [OP_W-1:0]      i_s_axis_tuser,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // in_window[0], read_data[32:1], flush_valid[33], flush_start[54:34],
    // flush_end[75:55], zero fill above
    output logic [OUT_W-1:0]     o_m_axis_tdata
);

    logic [BASE_W-1:0] r_window_base;
    logic              r_display_ready;

    logic              r_clr_busy;
    logic [ROW_W-1:0]  r_clr_row;

    logic              r_prod_flag, n_prod_flag;
    logic [OFF_W-1:0]  r_prod_low, n_prod_low;
    logic [OFF_W-1:0]  r_prod_high, n_prod_high;
    logic              r_pend_flag, n_pend_flag;
    logic [OFF_W-1:0]  r_pend_low, n_pend_low;
    logic [OFF_W-1:0]  r_pend_high, n_pend_high;

    logic              r_s1_valid;
    logic              r_s1_load;
    logic [1:0]        r_s1_off_lo;
    logic [2:0]        r_s1_width;
    t_result           r_s1_res, n_s1_res;

    logic              r_out_valid;
    t_result           r_out;
    t_result           w_s1_final;

    logic [OP_W-1:0]   w_op;
    logic [31:0]       w_addr;
    logic [2:0]        w_width;
    logic [31:0]       w_wdata;
    logic [OFF_W-1:0]  w_rq_start;
    logic [OFF_W-1:0]  w_rq_end;

    logic              w_accept;
    logic              w_out_free;
    logic [32:0]       w_off_full;
    logic [32:0]       w_end_full;
    logic              w_width_ok;
    logic              w_hit;
    logic              w_moves;
    logic [OFF_W-1:0]  w_off;
    logic [OFF_W-1:0]  w_end;
    logic              w_is_load;
    logic              w_is_store;

    logic [7:0]        w_rd [NB];

    assign w_op       = i_s_axis_tuser;
    assign w_addr     = i_s_axis_tdata[31:0];
    assign w_width    = i_s_axis_tdata[34:32];
    assign w_wdata    = i_s_axis_tdata[66:35];
    assign w_rq_start = i_s_axis_tdata[87:67];
    assign w_rq_end   = i_s_axis_tdata[108:88];

    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_clr_busy && (!r_s1_valid || w_out_free);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // Window check: the borrow bit of the subtraction flags an address below
    // the base, and the end of the access must not pass the framebuffer.
    assign w_off_full = {1'b0, w_addr} - {1'b0, r_window_base};
    assign w_end_full = {1'b0, w_off_full[31:0]} + {30'd0, w_width};
    assign w_width_ok = (w_width != 3'd0) && (w_width <= 3'd4);
    assign w_hit      = r_display_ready && w_width_ok && !w_off_full[32]
                        && (w_end_full <= 33'(FB_BYTES));
    assign w_moves    = w_hit && (w_width != 3'd3);
    assign w_off      = w_off_full[OFF_W-1:0];
    assign w_end      = w_end_full[OFF_W-1:0];
    assign w_is_load  = (w_op == OP_LOAD);
    assign w_is_store = (w_op == OP_STORE);

    // Byte banks: byte i of an access lands in bank (off + i) mod 4. A bank
    // below the start lane takes its byte from the next row.
    for (genvar b = 0; b < NB; b++) begin : g_bank
        logic [1:0]       w_lane;
        logic [ROW_W-1:0] w_row;
        logic             w_ben;
        logic [31:0]      w_shift;
        logic             w_we;
        logic             w_re;
        logic [ROW_W-1:0] w_ram_addr;
        logic [7:0]       w_ram_wdata;

        assign w_lane      = 2'(b) - w_off[1:0];
        assign w_row       = w_off[ROW_W+1:2] + ROW_W'(2'(b) < w_off[1:0]);
        assign w_ben       = {1'b0, w_lane} < w_width;
        assign w_shift     = w_wdata >> {w_lane, 3'b000};
        assign w_we        = r_clr_busy || (w_accept && w_is_store && w_moves && w_ben);
        assign w_re        = w_accept && w_is_load && w_moves && w_ben;
        assign w_ram_addr  = r_clr_busy ? r_clr_row : w_row;
        assign w_ram_wdata = r_clr_busy ? 8'd0 : w_shift[7:0];

        fbw_ram #(
            .P_WIDTH (8),
            .P_DEPTH (ROWS)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_we),
            .i_re    (w_re),
            .i_addr  (w_ram_addr),
            .i_wdata (w_ram_wdata),
            .o_rdata (w_rd[b])
        );
    end

    // Range bookkeeping and the non-load part of the result.
    always_comb begin
        n_prod_flag = r_prod_flag;
        n_prod_low  = r_prod_low;
        n_prod_high = r_prod_high;
        n_pend_flag = r_pend_flag;
        n_pend_low  = r_pend_low;
        n_pend_high = r_pend_high;
        n_s1_res    = '0;
        unique case (w_op)
            OP_LOAD: begin
                n_s1_res.in_window = w_hit;
            end
            OP_STORE: begin
                n_s1_res.in_window = w_hit;
                if (w_moves) begin
                    if (w_off < r_prod_low) begin
                        n_prod_low = w_off;
                    end
                    if (w_end > r_prod_high) begin
                        n_prod_high = w_end;
                    end
                    n_prod_flag = 1'b1;
                end
            end
            OP_COMMIT: begin
                if (r_prod_flag) begin
                    if (r_prod_low < r_pend_low) begin
                        n_pend_low = r_prod_low;
                    end
                    if (r_prod_high > r_pend_high) begin
                        n_pend_high = r_prod_high;
                    end
                    n_pend_flag = 1'b1;
                    n_prod_flag = 1'b0;
                    n_prod_low  = OFF_W'(FB_BYTES);
                    n_prod_high = '0;
                end
            end
            OP_FLUSH: begin
                if (r_pend_flag) begin
                    n_pend_flag = 1'b0;
                    n_pend_low  = OFF_W'(FB_BYTES);
                    n_pend_high = '0;
                    if ((r_pend_low < r_pend_high) && (r_pend_high <= OFF_W'(FB_BYTES))) begin
                        n_s1_res.flush_valid = 1'b1;
                        n_s1_res.flush_start = r_pend_low;
                        n_s1_res.flush_end   = r_pend_high;
                    end
                end
            end
            OP_REQUEUE: begin
                if ((w_rq_start < w_rq_end) && (w_rq_end <= OFF_W'(FB_BYTES))) begin
                    if (w_rq_start < r_pend_low) begin
                        n_pend_low = w_rq_start;
                    end
                    if (w_rq_end > r_pend_high) begin
                        n_pend_high = w_rq_end;
                    end
                    n_pend_flag = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Gather the loaded bytes back into little-endian order.
    always_comb begin
        logic [1:0] bank;
        w_s1_final           = r_s1_res;
        w_s1_final.read_data = '0;
        for (int i = 0; i < NB; i++) begin
            bank = r_s1_off_lo + 2'(i);
            if (r_s1_load && (3'(i) < r_s1_width)) begin
                w_s1_final.read_data[8*i +: 8] = w_rd[bank];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_base   <= '0;
            r_display_ready <= 1'b0;
            r_clr_busy      <= 1'b1;
            r_clr_row       <= '0;
            r_prod_flag     <= 1'b0;
            r_prod_low      <= OFF_W'(FB_BYTES);
            r_prod_high     <= '0;
            r_pend_flag     <= 1'b0;
            r_pend_low      <= OFF_W'(FB_BYTES);
            r_pend_high     <= '0;
            r_s1_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_WINDOW_BASE:   r_window_base   <= i_cfg_wdata;
                    REG_DISPLAY_READY: r_display_ready <= i_cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
            if (r_clr_busy) begin
                r_clr_row <= r_clr_row + 1'b1;
                if (r_clr_row == ROW_W'(ROWS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (w_accept) begin
                r_prod_flag <= n_prod_flag;
                r_prod_low  <= n_prod_low;
                r_prod_high <= n_prod_high;
                r_pend_flag <= n_pend_flag;
                r_pend_low  <= n_pend_low;
                r_pend_high <= n_pend_high;
            end
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_out_free) begin
                r_s1_valid <= 1'b0;
            end
            if (r_s1_valid && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_res    <= n_s1_res;
            r_s1_load   <= w_is_load && w_moves;
            r_s1_off_lo <= w_off[1:0];
            r_s1_width  <= w_width;
        end
        if (r_s1_valid && w_out_free) begin
            r_out <= w_s1_final;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(OUT_W - RES_W)'(0), r_out};

endmodule

// File: src/fbw_checker.sv
module fbw_checker
    import fbw_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_axis_tvalid,
    input logic                 o_s_axis_tready,
    input logic                 o_m_axis_tvalid,
    input logic                 i_m_axis_tready,
    input logic [OUT_W-1:0]     o_m_axis_tdata
);

    t_result w_res;

    assign w_res = t_result'(o_m_axis_tdata[RES_W-1:0]);

    // Reset empties the result path and starts the store clearing pass.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && !o_s_axis_tready)
        else $error("result or input ready active right after reset");

    // A result comes either from an access or from a flush, never both.
    a_kind_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(w_res.in_window && w_res.flush_valid))
        else $error("access hit and flush range in one result");

    a_flush_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && w_res.flush_valid
        |-> (w_res.flush_start < w_res.flush_end)
            && (w_res.flush_end <= OFF_W'(FB_BYTES)))
        else $error("flushed range is empty or out of bounds");

    a_flush_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !w_res.flush_valid
        |-> (w_res.flush_start == '0) && (w_res.flush_end == '0))
        else $error("flush range fields set without a valid flush");

    a_miss_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !w_res.in_window |-> (w_res.read_data == '0))
        else $error("read data returned without a window hit");

endmodule

bind framebuffer_window_dirty_range fbw_checker u_fbw_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

// File: tb/framebuffer_window_dirty_range_test.sv
module framebuffer_window_dirty_range_test;
    import fbw_pkg::*;

    localparam logic [OP_W-1:0] OP_RESERVED_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_RESERVED_LAST  = 3'd7;
    localparam int              DRAIN_SLACK       = 8;
    localparam int              MAX_REPORTS       = 100;
    localparam int unsigned     RQ_MAX            = (1 << OFF_W) - 1;

    // Input fields from the lowest bit up: bus_address, access_bytes,
    // write_data, requeue_start, requeue_end.
    typedef struct packed {
        logic [OFF_W-1:0] requeue_end;
        logic [OFF_W-1:0] requeue_start;
        logic [31:0]      write_data;
        logic [2:0]       access_bytes;
        logic [31:0]      bus_address;
    } fb_req_t;

    localparam int              REQ_W             = $bits(fb_req_t);

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = REG_WINDOW_BASE;
    logic [BASE_W-1:0]    cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic [IN_W-1:0]      s_tdata = '0;
    logic [OP_W-1:0]      s_tuser = OP_LOAD;
    logic                 m_tready = 1'b0;
    logic                 s_tready;
    logic                 m_tvalid;
    logic [OUT_W-1:0]     m_tdata;

    // Shadow of the block: frame bytes, dirty ranges and registers.
    bit [7:0]             frame_shadow [0:FB_BYTES-1];
    bit                   prod_dirty = 1'b0;
    int unsigned          prod_lo = FB_BYTES;
    int unsigned          prod_hi = 0;
    bit                   pend_dirty = 1'b0;
    int unsigned          pend_lo = FB_BYTES;
    int unsigned          pend_hi = 0;
    logic [31:0]          win_base = '0;
    bit                   disp_ready = 1'b0;

    t_result              awaited_results [$];
    int                   mismatch_count = 0;
    int                   send_idle_pct = 0;
    int                   recv_stall_pct = 0;
    bit                   hold_off = 1'b0;

    framebuffer_window_dirty_range dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #6000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_REPORTS) begin
            $display("MISMATCH at %0t: %s", $realtime, what);
        end
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
        end
    endtask

    // Works out the result of one accepted transaction and advances the shadow.
    function automatic t_result predict_window_step(input logic [OP_W-1:0] op,
                                                    input fb_req_t rq);
        t_result     res;
        int unsigned off;
        int unsigned width;
        int unsigned s;
        int unsigned e;
        bit          hit;
        logic [31:0] value;
        res   = '0;
        width = 32'(rq.access_bytes);
        off   = rq.bus_address - win_base;
        hit   = disp_ready && width >= 1 && width <= 4 && rq.bus_address >= win_base
                && off < FB_BYTES && width <= FB_BYTES - off;
        case (op)
            OP_LOAD, OP_STORE: begin
                if (hit) begin
                    res.in_window = 1'b1;
                    if (width != 3) begin
                        if (op == OP_LOAD) begin
                            value = '0;
                            for (int i = 0; i < width; i++)
                                value[8*i +: 8] = frame_shadow[off + i];
                            res.read_data = value;
                        end else begin
                            for (int i = 0; i < width; i++)
                                frame_shadow[off + i] = rq.write_data[8*i +: 8];
                            if (off < prod_lo) prod_lo = off;
                            if (off + width > prod_hi) prod_hi = off + width;
                            prod_dirty = 1'b1;
                        end
                    end
                end
            end
            OP_COMMIT: begin
                if (prod_dirty) begin
                    if (prod_lo < pend_lo) pend_lo = prod_lo;
                    if (prod_hi > pend_hi) pend_hi = prod_hi;
                    pend_dirty = 1'b1;
                    prod_dirty = 1'b0;
                    prod_lo    = FB_BYTES;
                    prod_hi    = 0;
                end
            end
            OP_FLUSH: begin
                if (pend_dirty) begin
                    s          = pend_lo;
                    e          = pend_hi;
                    pend_dirty = 1'b0;
                    pend_lo    = FB_BYTES;
                    pend_hi    = 0;
                    if (s < e && e <= FB_BYTES) begin
                        res.flush_valid = 1'b1;
                        res.flush_start = s[OFF_W-1:0];
                        res.flush_end   = e[OFF_W-1:0];
                    end
                end
            end
            OP_REQUEUE: begin
                s = 32'(rq.requeue_start);
                e = 32'(rq.requeue_end);
                if (s < e && e <= FB_BYTES) begin
                    if (s < pend_lo) pend_lo = s;
                    if (e > pend_hi) pend_hi = e;
                    pend_dirty = 1'b1;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        if (idx == REG_WINDOW_BASE) win_base = value;
        else disp_ready = value[0];
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Offers one transaction, with random idle cycles ahead of it, and
    // records the expected result once it is accepted.
    task automatic send_item(input logic [OP_W-1:0] op, input fb_req_t rq);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= IN_W'(rq);
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        awaited_results.push_back(predict_window_step(op, rq));
    endtask

    task automatic wait_for_drain();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    function automatic fb_req_t pack_request(input logic [31:0] addr, input int width,
                                             input logic [31:0] data,
                                             input int unsigned rs, input int unsigned re);
        fb_req_t rq;
        rq.bus_address   = addr;
        rq.access_bytes  = width[2:0];
        rq.write_data    = data;
        rq.requeue_start = rs[OFF_W-1:0];
        rq.requeue_end   = re[OFF_W-1:0];
        return rq;
    endfunction

    // Mostly accesses that land in a few hot spots of the window, so loads
    // see earlier stores, plus misses, odd widths and stray requeues.
    task automatic make_random_item(output logic [OP_W-1:0] op, output fb_req_t rq);
        int unsigned pick;
        int unsigned off;
        rq   = REQ_W'({$urandom(), $urandom(), $urandom(), $urandom()});
        pick = $urandom_range(99);
        if (pick < 32) op = OP_LOAD;
        else if (pick < 68) op = OP_STORE;
        else if (pick < 78) op = OP_COMMIT;
        else if (pick < 88) op = OP_FLUSH;
        else if (pick < 97) op = OP_REQUEUE;
        else op = OP_W'($urandom_range(OP_RESERVED_FIRST, OP_RESERVED_LAST));

        pick = $urandom_range(99);
        if (pick < 35) off = $urandom_range(255);
        else if (pick < 50) off = FB_BYTES - 1 - $urandom_range(7);
        else if (pick < 70) off = $urandom_range(FB_BYTES - 1);
        if (pick < 70) rq.bus_address = win_base + off;
        else if (pick < 80) rq.bus_address = win_base - 1 - $urandom_range(3);
        else if (pick < 88) rq.bus_address = win_base + FB_BYTES + $urandom_range(3);

        if ($urandom_range(99) < 80) begin
            case ($urandom_range(2))
                0: rq.access_bytes = 3'd1;
                1: rq.access_bytes = 3'd2;
                default: rq.access_bytes = 3'd4;
            endcase
        end

        pick = $urandom_range(99);
        if (pick < 60) begin
            rq.requeue_start = OFF_W'($urandom_range(FB_BYTES - 1));
            rq.requeue_end   = OFF_W'(32'(rq.requeue_start) + 1
                               + $urandom_range(FB_BYTES - 1 - 32'(rq.requeue_start)));
        end else if (pick < 75) begin
            rq.requeue_start = OFF_W'($urandom_range(FB_BYTES - 1));
            rq.requeue_end   = OFF_W'(FB_BYTES + $urandom_range(1));
        end else if (pick < 85) begin
            rq.requeue_end = rq.requeue_start;
        end
    endtask

    task automatic run_random_phase(input int count, input int idle, input int stall);
        logic [OP_W-1:0] op;
        fb_req_t         rq;
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        repeat (count) begin
            make_random_item(op, rq);
            send_item(op, rq);
        end
        wait_for_drain();
    endtask

    // With the display absent every access misses; ranges still work.
    task automatic test_display_off();
        send_item(OP_STORE, pack_request(32'h0, 4, 32'hFFFF_FFFF, 0, 0));
        send_item(OP_LOAD, pack_request(32'h0, 1, 32'h0, 0, 0));
        send_item(OP_FLUSH, pack_request(32'h0, 0, 32'h0, 0, 0));
        send_item(OP_COMMIT, pack_request(32'h0, 0, 32'h0, 0, 0));
        wait_for_drain();
    endtask

    task automatic test_load_store_widths();
        write_reg(REG_DISPLAY_READY, 32'd1);
        send_item(OP_LOAD, pack_request(32'h0, 4, 32'h0, 0, 0));
        send_item(OP_STORE, pack_request(32'h0, 4, 32'hA1B2_C3D4, 0, 0));
        send_item(OP_LOAD, pack_request(32'h0, 1, 32'h0, 0, 0));
        send_item(OP_LOAD, pack_request(32'h1, 2, 32'h0, 0, 0));
        send_item(OP_LOAD, pack_request(32'h0, 4, 32'h0, 0, 0));
        send_item(OP_STORE, pack_request(FB_BYTES - 2, 2, 32'h0000_BEEF, 0, 0));
        send_item(OP_STORE, pack_request(FB_BYTES - 2, 4, 32'h1234_5678, 0, 0));
        send_item(OP_LOAD, pack_request(FB_BYTES - 1, 1, 32'h0, 0, 0));
        // A three byte access hits the window but moves nothing.
        send_item(OP_STORE, pack_request(32'h4, 3, 32'hFFFF_FFFF, 0, 0));
        send_item(OP_LOAD, pack_request(32'h0, 3, 32'h0, 0, 0));
        send_item(OP_LOAD, pack_request(32'h0, 0, 32'h0, 0, 0));
        send_item(OP_LOAD, pack_request(32'hFFFF_FFFF, 7, 32'h0, 0, 0));
        wait_for_drain();
    endtask

    task automatic test_dirty_range_flow();
        send_item(OP_COMMIT, pack_request(32'h0, 0, 32'h0, 0, 0));
        send_item(OP_COMMIT, pack_request(32'h0, 0, 32'h0, 0, 0));
        send_item(OP_FLUSH, pack_request(32'h0, 0, 32'h0, 0, 0));
        send_item(OP_FLUSH, pack_request(32'h0, 0, 32'h0, 0, 0));
        send_item(OP_REQUEUE, pack_request(32'h0, 0, 32'h0, 100, 200));
        send_item(OP_REQUEUE, pack_request(32'h0, 0, 32'h0, 300, 300));
        send_item(OP_REQUEUE, pack_request(32'h0, 0, 32'h0, 0, RQ_MAX));
        send_item(OP_FLUSH, pack_request(32'h0, 0, 32'h0, 0, 0));
        send_item(OP_REQUEUE, pack_request(32'h0, 0, 32'h0, 0, FB_BYTES));
        send_item(OP_FLUSH, pack_request(32'h0, 0, 32'h0, 0, 0));
        send_item(OP_RESERVED_FIRST, pack_request(32'h0, 4, 32'hFFFF_FFFF, 1, 2));
        send_item(OP_RESERVED_LAST, pack_request(32'h0, 4, 32'hFFFF_FFFF, 1, 2));
        wait_for_drain();
    endtask

    // Windows that reach the end of the 32-bit bus space.
    task automatic test_window_at_top_of_bus();
        write_reg(REG_WINDOW_BASE, 32'hFFFF_FFFC);
        send_item(OP_STORE, pack_request(32'hFFFF_FFFE, 4, 32'hCAFE_F00D, 0, 0));
        send_item(OP_LOAD, pack_request(32'hFFFF_FFFF, 2, 32'h0, 0, 0));
        send_item(OP_LOAD, pack_request(32'h0000_0000, 1, 32'h0, 0, 0));
        wait_for_drain();
        write_reg(REG_WINDOW_BASE, 32'hFFF0_0000);
        send_item(OP_LOAD, pack_request(32'hFFFF_FFFE, 4, 32'h0, 0, 0));
        send_item(OP_LOAD, pack_request(32'hFFFF_FFFC, 4, 32'h0, 0, 0));
        wait_for_drain();
        write_reg(REG_WINDOW_BASE, 32'hFFFF_FFFF);
        send_item(OP_LOAD, pack_request(32'hFFFF_FFFF, 1, 32'h0, 0, 0));
        wait_for_drain();
    endtask

    task automatic test_random_traffic();
        write_reg(REG_WINDOW_BASE, 32'h0);
        run_random_phase(400, 0, 0);
        write_reg(REG_WINDOW_BASE, $urandom());
        run_random_phase(350, 74, 0);
        write_reg(REG_WINDOW_BASE, 32'hFFF0_0000);
        run_random_phase(350, 0, 74);
        write_reg(REG_DISPLAY_READY, 32'd0);
        run_random_phase(40, 38, 38);
        write_reg(REG_DISPLAY_READY, 32'd1);
        write_reg(REG_WINDOW_BASE, $urandom() | 32'h1);
        run_random_phase(350, 38, 38);
    endtask

    // The receiver holds off long enough for both result stages to fill
    // and the input to stall while the sender keeps offering.
    task automatic test_output_backpressure();
        logic [OP_W-1:0] op;
        fb_req_t         rq;
        write_reg(REG_WINDOW_BASE, 32'h0);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            begin
                repeat (60) begin
                    make_random_item(op, rq);
                    send_item(op, rq);
                end
            end
        join
        wait_for_drain();
    endtask

    always @(negedge i_clk) begin
        m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = t_result'(m_tdata[RES_W-1:0]);
            if (awaited_results.size() == 0) begin
                report_mismatch("result transaction with no expected result");
            end else begin
                want = awaited_results.pop_front();
                compare_field("in_window", 32'(got.in_window), 32'(want.in_window));
                compare_field("read_data", got.read_data, want.read_data);
                compare_field("flush_valid", 32'(got.flush_valid), 32'(want.flush_valid));
                compare_field("flush_start", 32'(got.flush_start), 32'(want.flush_start));
                compare_field("flush_end", 32'(got.flush_end), 32'(want.flush_end));
            end
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_display_off();
        test_load_store_widths();
        test_dirty_range_flow();
        test_window_at_top_of_bus();
        test_random_traffic();
        test_output_backpressure();
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: framebuffer_window_dirty_range.f
src/fbw_pkg.sv
src/fbw_ram.sv
src/framebuffer_window_dirty_range.sv
src/fbw_checker.sv
tb/framebuffer_window_dirty_range_test.sv
